@@ design/utf16_to_utf8_encoder_defines.svh @@
// Assertion macros for the UTF-16 to UTF-8 encoder back end (utf8e_back).
`ifndef UTF16_TO_UTF8_ENCODER_DEFINES_SVH
`define UTF16_TO_UTF8_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS

`define UTF8E_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("utf8e assertion failed");

`define UTF8E_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("utf8e forbidden condition seen");

`else

`define UTF8E_ASSERT(lbl, prop)

`define UTF8E_NEVER(lbl, expr)

`endif

`endif

@@ design/utf8e_pkg.sv @@
// Types and constants shared by the UTF-16 to UTF-8 encoder modules.
`default_nettype none

package utf8e_pkg;

    localparam int BYTE_W    = 8;
    localparam int JOB_BYTES = 6;
    localparam int CNT_W     = 3;
    localparam int UNIT_W    = 16;
    localparam int CFG_W     = 13;
    localparam int LIMIT_W   = 12;

    localparam logic [CFG_W-1:0]   MAX_BYTES_RESET = 13'd128;
    localparam logic [CFG_W-1:0]   MAX_BYTES_CAP   = 13'd4096;
    localparam logic [LIMIT_W-1:0] LIMIT_CAP       = 12'd4095;

    typedef struct packed {
        logic [JOB_BYTES*BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]            cnt;
        logic                        term;
    } job_t;

endpackage

`default_nettype wire

@@ design/utf16_to_utf8_encoder.sv @@
// Top level of the UTF-16 to UTF-8 encoder: limit register, front end, job queue, serializer.
//
//  Channel  Direction  Handshake            Payload
//  in       input      in_valid/in_stall    code_unit[15:0]
//  out      output     out_valid/out_stall  out_byte[7:0], is_terminator, last_of_run
//  cfg      input      cfg_wr_en            cfg_wr_data[12:0] (max_output_bytes)
//
// The front end takes one code unit per cycle while the job queue has room.
// The serializer sends one byte per cycle while out_stall is low; a unit causes from zero to six
// bytes, and a unit that causes no byte takes no place in the job queue.
// Reset clears the surrogate, count and queue state and sets the limit register to 128.
// Stalling the output fills the queue, after which in_stall rises.
`default_nettype none

module utf16_to_utf8_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [utf8e_pkg::UNIT_W-1:0]  code_unit,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [utf8e_pkg::BYTE_W-1:0]       out_byte,
    output logic                               is_terminator,
    output logic                               last_of_run,
    input  wire logic                          cfg_wr_en,
    input  wire logic [utf8e_pkg::CFG_W-1:0]   cfg_wr_data
);
    import utf8e_pkg::*;

    logic [CFG_W-1:0]   max_bytes_reg;
    logic [LIMIT_W-1:0] data_limit;
    logic               q_full, q_push, q_valid, q_pop;
    job_t               push_job, pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_bytes_reg <= MAX_BYTES_RESET;
        end else if (cfg_wr_en) begin
            max_bytes_reg <= cfg_wr_data;
        end
    end

    // Data bytes allowed per string; one place is kept for the terminator.
    always_comb
    begin
        if (max_bytes_reg == '0) begin
            data_limit = '0;
        end else if (max_bytes_reg >= MAX_BYTES_CAP) begin
            data_limit = LIMIT_CAP;
        end else begin
            data_limit = max_bytes_reg[LIMIT_W-1:0] - 1'b1;
        end
    end

    utf8e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .code_unit  (code_unit),
        .data_limit (data_limit),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (push_job)
    );

    utf8e_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_job   (pop_job)
    );

    utf8e_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_job         (pop_job),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .is_terminator (is_terminator),
        .last_of_run   (last_of_run)
    );

endmodule

`default_nettype wire

@@ design/utf8e_front.sv @@
// Front end: accepts code units, pairs surrogates, checks the buffer limit and builds byte jobs.
`default_nettype none

module utf8e_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [utf8e_pkg::UNIT_W-1:0]   code_unit,
    input  wire logic [utf8e_pkg::LIMIT_W-1:0]  data_limit,
    input  wire logic                           q_full,
    output logic                                q_push,
    output utf8e_pkg::job_t                     q_job
);
    import utf8e_pkg::*;

    localparam logic [5:0] HIGH_TAG = 6'b110110;
    localparam logic [5:0] LOW_TAG  = 6'b110111;

    typedef struct packed {
        logic [CNT_W-1:0]   n;
        logic [31:0]        bytes;
        logic [LIMIT_W-1:0] bw;
        logic               stop;
    } emit_t;

    function automatic emit_t emit_cp(input logic [20:0] cp, input logic [LIMIT_W-1:0] bw,
                                      input logic stp, input logic [LIMIT_W-1:0] lim);
        emit_t            r;
        logic [CNT_W-1:0] n;
        logic [LIMIT_W:0] sum;
        r.n     = '0;
        r.bytes = '0;
        r.bw    = bw;
        r.stop  = stp;
        if (cp < 21'h80) begin
            n = 3'd1;
        end else if (cp < 21'h800) begin
            n = 3'd2;
        end else if (cp < 21'h10000) begin
            n = 3'd3;
        end else begin
            n = 3'd4;
        end
        sum = {1'b0, bw} + {{(LIMIT_W+1-CNT_W){1'b0}}, n};
        if (stp) begin
            r.stop = 1'b1;
        end else if (bw >= lim) begin
            r.stop = 1'b1;
        end else if (sum > {1'b0, lim}) begin
            r.stop = 1'b1;
        end else begin
            r.n = n;
            unique case (n)
                3'd1: r.bytes = {cp[7:0], 24'b0};
                3'd2: r.bytes = {3'b110, cp[10:6], 2'b10, cp[5:0], 16'b0};
                3'd3: r.bytes = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'b0};
                3'd4: r.bytes = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                                 2'b10, cp[5:0]};
                default: r.bytes = '0;
            endcase
            r.bw   = sum[LIMIT_W-1:0];
            r.stop = (sum[LIMIT_W-1:0] >= lim);
        end
        return r;
    endfunction

    logic [9:0]         held_reg, held_next;
    logic               held_valid_reg, held_valid_next;
    logic [LIMIT_W-1:0] bw_reg, bw_next;
    logic               stop_reg, stop_next;

    logic               accept;
    logic               is_zero, is_low, is_high;
    logic [20:0]        pair_cp, held_cp, cp1;
    emit_t              e1, f, e2;
    logic [CNT_W-1:0]   n2;
    logic [JOB_BYTES*BYTE_W-1:0] v1, v2, v2_shifted;
    job_t               job;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        is_zero = (code_unit == '0);
        is_low  = (code_unit[15:10] == LOW_TAG);
        is_high = (code_unit[15:10] == HIGH_TAG);
        pair_cp = 21'h10000 + {1'b0, held_reg, code_unit[9:0]};
        held_cp = {5'b0, HIGH_TAG, held_reg};
        cp1     = (held_valid_reg && is_low && !is_zero) ? pair_cp : held_cp;
        e1      = emit_cp(cp1, bw_reg, stop_reg, data_limit);
        if (held_valid_reg) begin
            f = e1;
        end else begin
            f = '{n: '0, bytes: '0, bw: bw_reg, stop: stop_reg};
        end
        e2 = emit_cp({5'b0, code_unit}, f.bw, f.stop, data_limit);

        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        bw_next         = bw_reg;
        stop_next       = stop_reg;
        n2              = '0;
        v2              = '0;

        priority if (is_zero) begin
            // The terminator is a zero byte, so only its count matters here.
            n2              = 3'd1;
            held_next       = '0;
            held_valid_next = 1'b0;
            bw_next         = '0;
            stop_next       = 1'b0;
        end else if (stop_reg) begin
            held_next       = '0;
            held_valid_next = 1'b0;
        end else if (held_valid_reg && is_low) begin
            held_next       = '0;
            held_valid_next = 1'b0;
            bw_next         = f.bw;
            stop_next       = f.stop;
        end else begin
            held_next       = '0;
            held_valid_next = 1'b0;
            bw_next         = f.bw;
            stop_next       = f.stop;
            if (is_high) begin
                if (!f.stop) begin
                    if (f.bw >= data_limit) begin
                        stop_next = 1'b1;
                    end else begin
                        held_next       = code_unit[9:0];
                        held_valid_next = 1'b1;
                    end
                end
            end else begin
                n2        = e2.n;
                v2        = {e2.bytes, 16'b0};
                bw_next   = e2.bw;
                stop_next = e2.stop;
            end
        end

        v1         = {f.bytes, 16'b0};
        v2_shifted = v2 >> {f.n, 3'b000};
        job.bytes  = v1 | v2_shifted;
        job.cnt    = f.n + n2;
        job.term   = is_zero;
    end

    assign q_push = accept && (job.cnt != '0);
    assign q_job  = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            bw_reg         <= '0;
            stop_reg       <= 1'b0;
        end else if (accept) begin
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            bw_reg         <= bw_next;
            stop_reg       <= stop_next;
        end
    end

endmodule

`default_nettype wire

@@ design/utf8e_fifo.sv @@
// Short job queue between the front end and the byte serializer.
`default_nettype none

module utf8e_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire utf8e_pkg::job_t push_job,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output utf8e_pkg::job_t      pop_job
);
    import utf8e_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);

    job_t               mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W_Q-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == CNT_W_Q'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W_Q'(do_push) - CNT_W_Q'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ design/utf8e_back.sv @@
// Back end: serializes queued jobs into one output byte per beat.
`default_nettype none

`include "utf16_to_utf8_encoder_defines.svh"

module utf8e_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire utf8e_pkg::job_t               q_job,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [utf8e_pkg::BYTE_W-1:0]       out_byte,
    output logic                               is_terminator,
    output logic                               last_of_run
);
    import utf8e_pkg::*;

    localparam int VEC_W = JOB_BYTES * BYTE_W;

    logic [VEC_W-1:0]   cur_bytes_reg;
    logic [CNT_W-1:0]   cur_left_reg;
    logic               cur_term_reg;
    logic               cur_valid_reg;
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic               out_term_reg;
    logic               out_last_reg;

    logic               out_free, load, cur_last;

    assign out_free = !out_valid_reg || !out_stall;
    assign load     = cur_valid_reg && out_free;
    assign cur_last = (cur_left_reg == CNT_W'(1));
    assign q_pop    = q_valid && (!cur_valid_reg || (load && cur_last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            cur_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                cur_valid_reg <= 1'b1;
                cur_left_reg  <= q_job.cnt;
            end else if (load) begin
                cur_valid_reg <= !cur_last;
                cur_left_reg  <= cur_left_reg - 1'b1;
            end
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (out_free) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop) begin
            cur_bytes_reg <= q_job.bytes;
            cur_term_reg  <= q_job.term;
        end else if (load) begin
            cur_bytes_reg <= cur_bytes_reg << BYTE_W;
        end
        if (load) begin
            out_byte_reg <= cur_bytes_reg[VEC_W-1 -: BYTE_W];
            out_term_reg <= cur_term_reg && cur_last;
            out_last_reg <= cur_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign is_terminator = out_term_reg;
    assign last_of_run   = out_last_reg;

    `UTF8E_ASSERT(a_left_in_range,
        cur_valid_reg |-> (cur_left_reg != '0 && cur_left_reg <= CNT_W'(JOB_BYTES)))
    `UTF8E_ASSERT(a_term_is_last_nul,
        (out_valid_reg && out_term_reg) |-> (out_last_reg && out_byte_reg == '0))
    `UTF8E_ASSERT(a_term_byte_zero,
        (cur_valid_reg && cur_term_reg && cur_last) |-> (cur_bytes_reg[VEC_W-1 -: BYTE_W] == '0))
    `UTF8E_NEVER(a_load_while_stalled, load && out_valid_reg && out_stall)

endmodule

`default_nettype wire

@@ bench/utf8_stream_checker.sv @@
// Checker that predicts the UTF-8 byte stream from the observed code units and compares each output beat.
module utf8_stream_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [utf8e_pkg::UNIT_W-1:0] code_unit,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [utf8e_pkg::BYTE_W-1:0] out_byte,
    input  logic                         is_terminator,
    input  logic                         last_of_run,
    input  logic                         cfg_wr_en,
    input  logic [utf8e_pkg::CFG_W-1:0]  cfg_wr_data,
    output int                           mismatches,
    output int                           beats_pending
);
    import utf8e_pkg::*;

    localparam int unsigned HI_SURR_FIRST = 32'hD800;
    localparam int unsigned HI_SURR_LAST  = 32'hDBFF;
    localparam int unsigned LO_SURR_FIRST = 32'hDC00;
    localparam int unsigned LO_SURR_LAST  = 32'hDFFF;
    localparam int unsigned SUPP_BASE     = 32'h10000;
    localparam int unsigned TWO_BYTE_MIN  = 32'h80;
    localparam int unsigned THREE_BYTE_MIN = 32'h800;
    localparam int unsigned LEAD2         = 32'hC0;
    localparam int unsigned LEAD3         = 32'hE0;
    localparam int unsigned LEAD4         = 32'hF0;
    localparam int unsigned CONT          = 32'h80;
    localparam int unsigned CONT_MASK     = 32'h3F;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_val;
        logic              term;
        logic              run_end;
    } utf8_beat_t;

    utf8_beat_t          expected_beats[$];
    logic [CFG_W-1:0]    max_bytes;
    logic [9:0]          held_hi;
    logic                held_v;
    logic [LIMIT_W-1:0]  written;
    logic                stopped;
    int                  run_count;

    function automatic int unsigned byte_budget();
        int unsigned m;
        m = max_bytes;
        if (m < 1)
        begin
            m = 1;
        end
        if (m > MAX_BYTES_CAP)
        begin
            m = MAX_BYTES_CAP;
        end
        return m - 1;
    endfunction

    task automatic push_byte(input int unsigned b, input logic t);
        utf8_beat_t beat;
        beat.byte_val = BYTE_W'(b);
        beat.term     = t;
        beat.run_end  = 1'b0;
        expected_beats.push_back(beat);
        run_count++;
    endtask

    task automatic encode_point(input int unsigned cp);
        int unsigned lim;
        int unsigned n;
        lim = byte_budget();
        if (stopped)
        begin
            return;
        end
        if (written >= lim)
        begin
            stopped = 1'b1;
            return;
        end
        n = (cp < TWO_BYTE_MIN) ? 1 : (cp < THREE_BYTE_MIN) ? 2 : (cp < SUPP_BASE) ? 3 : 4;
        if (written + n > lim)
        begin
            stopped = 1'b1;
            return;
        end
        case (n)
            1: push_byte(cp, 1'b0);
            2:
            begin
                push_byte(LEAD2 | (cp >> 6), 1'b0);
                push_byte(CONT | (cp & CONT_MASK), 1'b0);
            end
            3:
            begin
                push_byte(LEAD3 | (cp >> 12), 1'b0);
                push_byte(CONT | ((cp >> 6) & CONT_MASK), 1'b0);
                push_byte(CONT | (cp & CONT_MASK), 1'b0);
            end
            default:
            begin
                push_byte(LEAD4 | (cp >> 18), 1'b0);
                push_byte(CONT | ((cp >> 12) & CONT_MASK), 1'b0);
                push_byte(CONT | ((cp >> 6) & CONT_MASK), 1'b0);
                push_byte(CONT | (cp & CONT_MASK), 1'b0);
            end
        endcase
        written = LIMIT_W'(written + n);
        if (written >= lim)
        begin
            stopped = 1'b1;
        end
    endtask

    task automatic predict_unit(input logic [UNIT_W-1:0] u);
        logic paired;
        run_count = 0;
        paired    = 1'b0;
        if (u == '0)
        begin
            if (held_v)
            begin
                encode_point(HI_SURR_FIRST + held_hi);
            end
            push_byte(0, 1'b1);
            held_hi = '0;
            held_v  = 1'b0;
            written = '0;
            stopped = 1'b0;
        end
        else if (stopped)
        begin
            held_v  = 1'b0;
            held_hi = '0;
        end
        else
        begin
            if (held_v)
            begin
                held_v = 1'b0;
                if (u >= LO_SURR_FIRST && u <= LO_SURR_LAST)
                begin
                    encode_point(SUPP_BASE + (int'(held_hi) << 10) + (u - LO_SURR_FIRST));
                    paired = 1'b1;
                end
                else
                begin
                    encode_point(HI_SURR_FIRST + held_hi);
                end
                held_hi = '0;
            end
            if (!paired)
            begin
                if (u >= HI_SURR_FIRST && u <= HI_SURR_LAST)
                begin
                    if (!stopped)
                    begin
                        if (written >= byte_budget())
                        begin
                            stopped = 1'b1;
                        end
                        else
                        begin
                            held_hi = 10'(u - HI_SURR_FIRST);
                            held_v  = 1'b1;
                        end
                    end
                end
                else
                begin
                    encode_point(u);
                end
            end
        end
        if (run_count > 0)
        begin
            expected_beats[expected_beats.size() - 1].run_end = 1'b1;
        end
    endtask

    task automatic check_beat();
        utf8_beat_t want;
        if (expected_beats.size() == 0)
        begin
            $error("out_byte expected none actual %0h", out_byte);
            mismatches++;
            return;
        end
        want = expected_beats.pop_front();
        if (out_byte !== want.byte_val)
        begin
            $error("out_byte expected %0h actual %0h", want.byte_val, out_byte);
            mismatches++;
        end
        if (is_terminator !== want.term)
        begin
            $error("is_terminator expected %0b actual %0b", want.term, is_terminator);
            mismatches++;
        end
        if (last_of_run !== want.run_end)
        begin
            $error("last_of_run expected %0b actual %0b", want.run_end, last_of_run);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes  = MAX_BYTES_RESET;
            held_hi    = '0;
            held_v     = 1'b0;
            written    = '0;
            stopped    = 1'b0;
            mismatches = 0;
            expected_beats.delete();
            beats_pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_bytes = cfg_wr_data;
            end
            if (in_valid && !in_stall)
            begin
                predict_unit(code_unit);
            end
            if (out_valid && !out_stall)
            begin
                check_beat();
            end
            beats_pending <= expected_beats.size();
        end
    end

endmodule

@@ bench/tb_utf16_to_utf8_encoder.sv @@
// Testbench top for the UTF-16 to UTF-8 encoder: clock, reset, stimulus, receiver and verdict.
module tb_utf16_to_utf8_encoder;
    import utf8e_pkg::*;

    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PCT     = 31;
    localparam int RANDOM_UNITS = 300;
    localparam int PHASES       = 10;

    localparam logic [UNIT_W-1:0] STRING_END = 16'h0000;
    localparam int unsigned HI_SURR_FIRST = 32'hD800;
    localparam int unsigned LO_SURR_FIRST = 32'hDC00;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic [UNIT_W-1:0]   code_unit   = '0;
    logic                out_stall   = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]    cfg_wr_data = '0;
    logic                in_stall;
    logic                out_valid;
    logic [BYTE_W-1:0]   out_byte;
    logic                is_terminator;
    logic                last_of_run;
    int                  mismatches;
    int                  beats_pending;
    bit                  tx_steady   = 1'b0;
    bit                  rx_steady   = 1'b0;
    bit                  rx_hold_req = 1'b0;
    int                  units_sent  = 0;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    utf16_to_utf8_encoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .code_unit     (code_unit),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .is_terminator (is_terminator),
        .last_of_run   (last_of_run),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    utf8_stream_checker stream_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .code_unit     (code_unit),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .is_terminator (is_terminator),
        .last_of_run   (last_of_run),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .mismatches    (mismatches),
        .beats_pending (beats_pending)
    );

    task automatic send_unit(input logic [UNIT_W-1:0] u);
        if (!tx_steady)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        code_unit <= u;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        units_sent++;
    endtask

    task automatic drain_output();
        in_valid <= 1'b0;
        @(posedge clk);
        while (beats_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] v);
        drain_output();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [UNIT_W-1:0] text_unit();
        case ($urandom_range(0, 3))
            0: return UNIT_W'($urandom_range(16'h0001, 16'h007F));
            1: return UNIT_W'($urandom_range(16'h0080, 16'h07FF));
            2: return UNIT_W'($urandom_range(16'h0800, 16'hD7FF));
            default: return UNIT_W'($urandom_range(16'hE000, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0: return CFG_W'($urandom_range(1, 8));
            1: return CFG_W'($urandom_range(9, 40));
            2, 3: return CFG_W'($urandom_range(41, 300));
            4: return CFG_W'($urandom_range(4096, 8191));
            default: return CFG_W'($urandom_range(0, 8191));
        endcase
    endfunction

    task automatic send_string(input int len);
        int r;
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                send_unit(UNIT_W'(HI_SURR_FIRST + $urandom_range(0, 1023)));
                send_unit(UNIT_W'(LO_SURR_FIRST + $urandom_range(0, 1023)));
            end
            else if (r < 22)
            begin
                send_unit(UNIT_W'($urandom_range(1, 16'hFFFF)));
            end
            else if (r < 25)
            begin
                send_unit(UNIT_W'(LO_SURR_FIRST + $urandom_range(0, 1023)));
            end
            else if (r < 28)
            begin
                send_unit(UNIT_W'(HI_SURR_FIRST + $urandom_range(0, 1023)));
            end
            else
            begin
                send_unit(text_unit());
            end
        end
        if ($urandom_range(0, 9) != 0)
        begin
            send_unit(STRING_END);
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            else if (rx_steady)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int phase_start;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_unit(16'h0041);
        send_unit(16'h0080);
        send_unit(16'h07FF);
        send_unit(16'h0800);
        send_unit(16'hFFFF);
        send_unit(16'hD800);
        send_unit(16'hDC00);
        send_unit(16'hDBFF);
        send_unit(16'hDFFF);
        send_unit(16'hDC00);
        send_unit(16'hD800);
        send_unit(16'hE000);
        send_unit(16'hDBFF);
        send_unit(16'hD800);
        send_unit(STRING_END);

        write_limit(13'd3);
        send_unit(16'h0041);
        send_unit(16'hD800);
        send_unit(STRING_END);

        write_limit(13'd4);
        send_unit(16'h0041);
        send_unit(16'h0800);
        send_unit(16'h0042);
        send_unit(STRING_END);

        write_limit(13'd0);
        send_unit(16'h0041);
        send_unit(STRING_END);

        write_limit(13'd8191);
        send_unit(16'hD83D);
        send_unit(16'hDE00);
        send_unit(STRING_END);

        write_limit(13'd128);
        send_unit(16'h0041);
        send_unit(16'h0042);
        write_limit(13'd3);
        send_unit(16'h0043);
        send_unit(STRING_END);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 5)
            begin
                write_limit(13'd4096);
                rx_hold_req = 1'b1;
                for (int i = 0; i < 30; i++)
                begin
                    send_unit(text_unit());
                end
                send_unit(STRING_END);
            end
            else
            begin
                write_limit(pick_limit());
            end
            tx_steady   = (phase == 3);
            rx_steady   = (phase == 3);
            phase_start = units_sent;
            while (units_sent - phase_start < RANDOM_UNITS / PHASES)
            begin
                send_string($urandom_range(0, 20));
            end
            tx_steady = 1'b0;
            rx_steady = 1'b0;
        end

        drain_output();
        if (mismatches == 0 && beats_pending == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
